// ----- sv/grid_astar_first_step_defines.svh -----
// ----------------------------------------------------------------------------
// Grid A* first-step finder: assertion macros
// Shared concurrent assertion forms for the search block and its open list.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_FIRST_STEP_DEFINES_SVH
`define GRID_ASTAR_FIRST_STEP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GAS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define GAS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/gas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* first-step finder: package
// Widths, codes and shared types of the search block and its open list.
// ----------------------------------------------------------------------------
package gas_pkg;

  localparam int FIELD_W = 5;
  localparam int COORD_W = 6;
  localparam int CFG_W = 6;
  localparam int CFG_IDX_W = 1;
  localparam int AREA_W = 7;
  localparam int PAR_W = 3;

  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_GRID_COLS = 32;
  localparam int DEF_OPEN_DEPTH = 4096;
  localparam int DEF_KEY_W = 23;

  localparam logic [CFG_W-1:0] AREA_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [1:0] DIR_LEFT = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP = 2'd2;
  localparam logic [1:0] DIR_DOWN = 2'd3;
  localparam logic [PAR_W-1:0] PAR_START = 3'd4;

  typedef enum logic [1:0] {
    ST_STEP,
    ST_HOME,
    ST_NOPATH,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } heap_req_t;

  typedef struct packed {
    logic done;
    logic ok;
    logic empty;
  } heap_rsp_t;

  function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- sv/gas_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* first-step finder: request channel
// Valid/ready channel that carries load and search items.
// ----------------------------------------------------------------------------
interface gas_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [gas_pkg::FIELD_W-1:0] cell_row;
  logic [gas_pkg::FIELD_W-1:0] cell_col;
  logic                        cell_blocked;
  logic [gas_pkg::FIELD_W-1:0] start_row;
  logic [gas_pkg::FIELD_W-1:0] start_col;
  logic [gas_pkg::FIELD_W-1:0] dest_row;
  logic [gas_pkg::FIELD_W-1:0] dest_col;

  modport source (output valid, req_type, cell_row, cell_col, cell_blocked,
                  start_row, start_col, dest_row, dest_col, input ready);
  modport sink (input valid, req_type, cell_row, cell_col, cell_blocked,
                start_row, start_col, dest_row, dest_col, output ready);
endinterface

// ----- sv/gas_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* first-step finder: result channel
// Valid/ready channel that carries one result item per search.
// ----------------------------------------------------------------------------
interface gas_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [1:0]                  step_dir;
  logic [gas_pkg::FIELD_W-1:0] step_row;
  logic [gas_pkg::FIELD_W-1:0] step_col;
  logic                        step_reaches_goal;

  modport source (output valid, status, step_dir, step_row, step_col,
                  step_reaches_goal, input ready);
  modport sink (input valid, status, step_dir, step_row, step_col,
                step_reaches_goal, output ready);
endinterface

// ----- sv/gas_heap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* first-step finder: open list
// Binary min-heap in a synchronous memory with push, pop and clear.
// ----------------------------------------------------------------------------
module gas_heap #(
  parameter int DEPTH = gas_pkg::DEF_OPEN_DEPTH,
  parameter int KEY_W = gas_pkg::DEF_KEY_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gas_pkg::heap_req_t req,
  input  logic [KEY_W-1:0]   key_in,
  output gas_pkg::heap_rsp_t rsp,
  output logic [KEY_W-1:0]   top_key
);
  import gas_pkg::*;
  `include "grid_astar_first_step_defines.svh"

  localparam int HAW = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IX_W = HAW + 2;

  typedef enum logic [2:0] {
    H_IDLE,
    H_PUSH_CMP,
    H_PUSH_FIN,
    H_POP_LAST,
    H_POP_CMP,
    H_POP_FIN
  } hstate_t;

  hstate_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [HAW-1:0] k_r, k_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] top_r, top_nxt;
  logic done_r, done_nxt, ok_r, ok_nxt;

  logic [KEY_W-1:0] heap_mem [DEPTH];
  logic [KEY_W-1:0] rd_a_q, rd_b_q;
  logic [HAW-1:0] ra, rb, wa;
  logic we;
  logic [KEY_W-1:0] wd;

  logic [IX_W-1:0] c_ix, c1_ix, ch_ix, gc_ix, cnt_x;
  logic [HAW-1:0] p_ix;
  logic use_b;
  logic [KEY_W-1:0] ch_key;

  always_comb begin
    c_ix = {1'b0, k_r, 1'b1};
    c1_ix = c_ix + IX_W'(1);
    cnt_x = IX_W'(cnt_r);
    use_b = (c1_ix < cnt_x) && (rd_b_q < rd_a_q);
    ch_key = use_b ? rd_b_q : rd_a_q;
    ch_ix = use_b ? c1_ix : c_ix;
    gc_ix = {1'b0, ch_ix[HAW-1:0], 1'b1};
    p_ix = (k_r - HAW'(1)) >> 1;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    k_nxt = k_r;
    key_nxt = key_r;
    top_nxt = top_r;
    done_nxt = 1'b0;
    ok_nxt = ok_r;
    ra = '0;
    rb = '0;
    we = 1'b0;
    wa = k_r;
    wd = key_r;
    case (state_r)
      H_IDLE: begin
        if (req.clear) begin
          cnt_nxt = '0;
        end else if (req.push) begin
          if (cnt_r == CNT_W'(DEPTH)) begin
            done_nxt = 1'b1;
            ok_nxt = 1'b0;
          end else begin
            k_nxt = HAW'(cnt_r);
            cnt_nxt = cnt_r + CNT_W'(1);
            key_nxt = key_in;
            ra = HAW'((cnt_r - CNT_W'(1)) >> 1);
            state_nxt = (cnt_r == '0) ? H_PUSH_FIN : H_PUSH_CMP;
          end
        end else if (req.pop) begin
          ra = '0;
          rb = HAW'(cnt_r - CNT_W'(1));
          cnt_nxt = cnt_r - CNT_W'(1);
          state_nxt = H_POP_LAST;
        end
      end
      H_PUSH_CMP: begin
        if (rd_a_q <= key_r) begin
          state_nxt = H_PUSH_FIN;
        end else begin
          we = 1'b1;
          wd = rd_a_q;
          k_nxt = p_ix;
          ra = (p_ix - HAW'(1)) >> 1;
          if (p_ix == '0) state_nxt = H_PUSH_FIN;
        end
      end
      H_PUSH_FIN: begin
        we = 1'b1;
        done_nxt = 1'b1;
        ok_nxt = 1'b1;
        state_nxt = H_IDLE;
      end
      H_POP_LAST: begin
        top_nxt = rd_a_q;
        key_nxt = rd_b_q;
        k_nxt = '0;
        ra = HAW'(1);
        rb = HAW'(2);
        state_nxt = (cnt_r <= CNT_W'(1)) ? H_POP_FIN : H_POP_CMP;
      end
      H_POP_CMP: begin
        if (ch_key >= key_r) begin
          state_nxt = H_POP_FIN;
        end else begin
          we = 1'b1;
          wd = ch_key;
          k_nxt = ch_ix[HAW-1:0];
          ra = gc_ix[HAW-1:0];
          rb = HAW'(gc_ix + IX_W'(1));
          if (gc_ix >= cnt_x) state_nxt = H_POP_FIN;
        end
      end
      H_POP_FIN: begin
        we = (cnt_r != '0);
        done_nxt = 1'b1;
        ok_nxt = 1'b1;
        state_nxt = H_IDLE;
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_a_q <= heap_mem[ra];
    rd_b_q <= heap_mem[rb];
    if (we) heap_mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      cnt_r <= '0;
      done_r <= 1'b0;
      ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
      ok_r <= ok_nxt;
      k_r <= k_nxt;
      key_r <= key_nxt;
      top_r <= top_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.ok = ok_r;
  assign rsp.empty = (cnt_r == '0);
  assign top_key = top_r;

  `GAS_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `GAS_ASSERT_IMPL(a_done_idle, clk, rst_n, done_r, state_r == H_IDLE)
  `GAS_ASSERT_IMPL(a_fail_full, clk, rst_n, done_r && !ok_r, cnt_r == CNT_W'(DEPTH))
  `GAS_ASSERT_NEXT(a_push_starts, clk, rst_n, req.push && !req.clear && state_r == H_IDLE,
                   state_r != H_IDLE || done_r)

endmodule

// ----- sv/grid_astar_first_step.sv -----
// A load item writes the blocked map from idle; the block is ready again on the next cycle.
// A search item first clears the per-search cell memory, then for each expanded
// cell pops the heap and pushes each neighbor that it opens.
// After reset a sweep over all GRID_ROWS*GRID_COLS cells clears the blocked map;
// no item is taken meanwhile, configuration writes are.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid A* first-step finder
// Keeps a blocked map, runs A* on request and reports the first move.
// ----------------------------------------------------------------------------
module grid_astar_first_step #(
  parameter int GRID_ROWS = gas_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = gas_pkg::DEF_GRID_COLS,
  parameter int OPEN_DEPTH = gas_pkg::DEF_OPEN_DEPTH
) (
  input logic                          clk,
  input logic                          rst_n,
  gas_in_if.sink                       in_ch,
  gas_out_if.source                    out_ch,
  input logic                          cfg_we,
  input logic [gas_pkg::CFG_IDX_W-1:0] cfg_idx,
  input logic [gas_pkg::CFG_W-1:0]     cfg_wdata
);
  import gas_pkg::*;
  `include "grid_astar_first_step_defines.svh"

  // Cell memory word: closed flag, cost g, best f and the parent move.
  localparam int NCELLS = GRID_ROWS * GRID_COLS;
  localparam int AW = $clog2(NCELLS);
  localparam int F_W = $clog2(NCELLS + 2 * 64 + 2);
  localparam int KEY_W = F_W + 2 * COORD_W;
  localparam int CE_W = 1 + 2 * F_W + PAR_W;
  localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
  localparam logic [CE_W-1:0] CE_INIT = {1'b0, {F_W{1'b1}}, {F_W{1'b1}}, {PAR_W{1'b0}}};

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_SEED,
    S_SEED_W,
    S_POP,
    S_POP_W,
    S_CUR,
    S_NB,
    S_NB_CHK,
    S_NB_PUSH,
    S_TR,
    S_TR_CHK,
    S_DONE
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                              input logic [COORD_W-1:0] c);
    return AW'(int'(r) * GRID_COLS + int'(c));
  endfunction

  state_t state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [COORD_W-1:0] sr_r, sr_nxt, sc_r, sc_nxt, dr_r, dr_nxt, dc_r, dc_nxt;
  logic [COORD_W-1:0] cr_r, cr_nxt, cc_r, cc_nxt, nr_r, nr_nxt, nc_r, nc_nxt;
  logic [COORD_W-1:0] tr_r, tr_nxt, tc_r, tc_nxt;
  logic [COORD_W-1:0] step_row_r, step_row_nxt, step_col_r, step_col_nxt;
  logic [1:0] step_dir_r, step_dir_nxt, d_r, d_nxt;
  logic [F_W-1:0] g_r, g_nxt, fn_r, fn_nxt;
  status_t res_status_r, res_status_nxt;
  logic [1:0] res_dir_r, res_dir_nxt;
  logic [FIELD_W-1:0] res_row_r, res_row_nxt, res_col_r, res_col_nxt;
  logic res_goal_r, res_goal_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt, out_dir_r, out_dir_nxt;
  logic [FIELD_W-1:0] out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic out_goal_r, out_goal_nxt;

  // Blocked map and per-search cell memory, both with registered reads.
  logic blocked_mem [NCELLS];
  logic [CE_W-1:0] cell_mem [NCELLS];
  logic bm_q, bm_we, bm_wdata;
  logic [AW-1:0] bm_raddr, bm_waddr, cm_raddr, cm_waddr;
  logic [CE_W-1:0] cm_q, cm_wdata;
  logic cm_we;

  heap_req_t hp_req;
  heap_rsp_t hp_rsp;
  logic [KEY_W-1:0] hp_key, hp_top;

  logic [AREA_W-1:0] rows_eff, cols_eff;
  logic nb_ok, nb_dest;
  logic [COORD_W-1:0] nb_r, nb_c, hp_top_r, hp_top_c;
  logic [F_W-1:0] fn_c, q_cost, q_bestf;
  logic q_closed;
  logic [PAR_W-1:0] q_par;

  gas_heap #(
    .DEPTH (OPEN_DEPTH),
    .KEY_W (KEY_W)
  ) u_heap (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hp_req),
    .key_in  (hp_key),
    .rsp     (hp_rsp),
    .top_key (hp_top)
  );

  always_ff @(posedge clk) begin
    bm_q <= blocked_mem[bm_raddr];
    cm_q <= cell_mem[cm_raddr];
    if (bm_we) blocked_mem[bm_waddr] <= bm_wdata;
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
  end

  // Area registers: zero counts as one, anything past the grid as the grid.
  always_comb begin
    if (rows_r == '0) rows_eff = AREA_W'(1);
    else if ({1'b0, rows_r} > AREA_W'(GRID_ROWS)) rows_eff = AREA_W'(GRID_ROWS);
    else rows_eff = {1'b0, rows_r};
    if (cols_r == '0) cols_eff = AREA_W'(1);
    else if ({1'b0, cols_r} > AREA_W'(GRID_COLS)) cols_eff = AREA_W'(GRID_COLS);
    else cols_eff = {1'b0, cols_r};
  end

  // Neighbor of the expanded cell in the current direction.
  always_comb begin
    nb_r = cr_r;
    nb_c = cc_r;
    case (d_r)
      DIR_LEFT: begin
        nb_ok = (cc_r != '0);
        nb_c = cc_r - COORD_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok = ({1'b0, cc_r} + AREA_W'(1)) < cols_eff;
        nb_c = cc_r + COORD_W'(1);
      end
      DIR_UP: begin
        nb_ok = (cr_r != '0);
        nb_r = cr_r - COORD_W'(1);
      end
      DIR_DOWN: begin
        nb_ok = ({1'b0, cr_r} + AREA_W'(1)) < rows_eff;
        nb_r = cr_r + COORD_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
    nb_dest = (nb_r == dr_r) && (nb_c == dc_r);
  end

  assign q_closed = cm_q[CE_W-1];
  assign q_cost = cm_q[CE_W-2 -: F_W];
  assign q_bestf = cm_q[CE_W-2-F_W -: F_W];
  assign q_par = cm_q[PAR_W-1:0];
  assign fn_c = g_r + F_W'(1) + F_W'(absdiff(nr_r, dr_r)) + F_W'(absdiff(nc_r, dc_r));
  assign hp_top_r = hp_top[2*COORD_W-1:COORD_W];
  assign hp_top_c = hp_top[COORD_W-1:0];

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    sr_nxt = sr_r;
    sc_nxt = sc_r;
    dr_nxt = dr_r;
    dc_nxt = dc_r;
    cr_nxt = cr_r;
    cc_nxt = cc_r;
    nr_nxt = nr_r;
    nc_nxt = nc_r;
    tr_nxt = tr_r;
    tc_nxt = tc_r;
    step_row_nxt = step_row_r;
    step_col_nxt = step_col_r;
    step_dir_nxt = step_dir_r;
    d_nxt = d_r;
    g_nxt = g_r;
    fn_nxt = fn_r;
    res_status_nxt = res_status_r;
    res_dir_nxt = res_dir_r;
    res_row_nxt = res_row_r;
    res_col_nxt = res_col_r;
    res_goal_nxt = res_goal_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_dir_nxt = out_dir_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    out_goal_nxt = out_goal_r;
    bm_raddr = cell_addr(nb_r, nb_c);
    bm_we = 1'b0;
    bm_waddr = sweep_r;
    bm_wdata = 1'b0;
    cm_raddr = cell_addr(nb_r, nb_c);
    cm_we = 1'b0;
    cm_waddr = sweep_r;
    cm_wdata = CE_INIT;
    hp_req = '0;
    hp_key = {fn_c, nr_r, nc_r};

    // Configuration is taken in any state.
    if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS: rows_nxt = cfg_wdata;
        REG_COLS: cols_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_INIT: begin
        bm_we = 1'b1;
        cm_we = 1'b1;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_CELL) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          if (!in_ch.req_type) begin
            // Loads outside the grid are dropped.
            bm_we = (int'(in_ch.cell_row) < GRID_ROWS) && (int'(in_ch.cell_col) < GRID_COLS);
            bm_waddr = cell_addr({1'b0, in_ch.cell_row}, {1'b0, in_ch.cell_col});
            bm_wdata = in_ch.cell_blocked;
          end else begin
            sr_nxt = {1'b0, in_ch.start_row};
            sc_nxt = {1'b0, in_ch.start_col};
            dr_nxt = {1'b0, in_ch.dest_row};
            dc_nxt = {1'b0, in_ch.dest_col};
            res_dir_nxt = '0;
            res_row_nxt = '0;
            res_col_nxt = '0;
            res_goal_nxt = 1'b0;
            if (in_ch.start_row == in_ch.dest_row && in_ch.start_col == in_ch.dest_col) begin
              res_status_nxt = ST_HOME;
              state_nxt = S_DONE;
            end else if (!({2'b0, in_ch.start_row} < rows_eff) ||
                         !({2'b0, in_ch.start_col} < cols_eff)) begin
              res_status_nxt = ST_NOPATH;
              state_nxt = S_DONE;
            end else begin
              hp_req.clear = 1'b1;
              sweep_nxt = '0;
              state_nxt = S_CLR;
            end
          end
        end
      end
      S_CLR: begin
        cm_we = 1'b1;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_CELL) begin
          sweep_nxt = '0;
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cm_we = 1'b1;
        cm_waddr = cell_addr(sr_r, sc_r);
        cm_wdata = {1'b0, {F_W{1'b0}}, {F_W{1'b0}}, PAR_START};
        hp_req.push = 1'b1;
        hp_key = {{F_W{1'b0}}, sr_r, sc_r};
        state_nxt = S_SEED_W;
      end
      S_SEED_W: begin
        if (hp_rsp.done) state_nxt = S_POP;
      end
      S_POP: begin
        if (hp_rsp.empty) begin
          res_status_nxt = ST_NOPATH;
          state_nxt = S_DONE;
        end else begin
          hp_req.pop = 1'b1;
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        if (hp_rsp.done) begin
          cr_nxt = hp_top_r;
          cc_nxt = hp_top_c;
          cm_raddr = cell_addr(hp_top_r, hp_top_c);
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        // Stale entries are expanded again with the stored cost.
        g_nxt = q_cost;
        cm_we = 1'b1;
        cm_waddr = cell_addr(cr_r, cc_r);
        cm_wdata = {1'b1, cm_q[CE_W-2:0]};
        d_nxt = DIR_LEFT;
        state_nxt = S_NB;
      end
      S_NB: begin
        if (!nb_ok) begin
          d_nxt = d_r + 2'd1;
          state_nxt = (d_r == DIR_DOWN) ? S_POP : S_NB;
        end else if (nb_dest) begin
          // The goal is taken on sight, blocked or not.
          cm_we = 1'b1;
          cm_waddr = cell_addr(nb_r, nb_c);
          cm_wdata = {1'b0, {F_W{1'b1}}, {F_W{1'b1}}, 1'b0, d_r};
          tr_nxt = dr_r;
          tc_nxt = dc_r;
          step_row_nxt = dr_r;
          step_col_nxt = dc_r;
          step_dir_nxt = DIR_LEFT;
          state_nxt = S_TR;
        end else begin
          nr_nxt = nb_r;
          nc_nxt = nb_c;
          state_nxt = S_NB_CHK;
        end
      end
      S_NB_CHK: begin
        fn_nxt = fn_c;
        if (!q_closed && !bm_q && (q_bestf > fn_c)) begin
          hp_req.push = 1'b1;
          state_nxt = S_NB_PUSH;
        end else begin
          d_nxt = d_r + 2'd1;
          state_nxt = (d_r == DIR_DOWN) ? S_POP : S_NB;
        end
      end
      S_NB_PUSH: begin
        if (hp_rsp.done) begin
          if (!hp_rsp.ok) begin
            res_status_nxt = ST_OVERFLOW;
            state_nxt = S_DONE;
          end else begin
            cm_we = 1'b1;
            cm_waddr = cell_addr(nr_r, nc_r);
            cm_wdata = {1'b0, g_r + F_W'(1), fn_r, 1'b0, d_r};
            d_nxt = d_r + 2'd1;
            state_nxt = (d_r == DIR_DOWN) ? S_POP : S_NB;
          end
        end
      end
      S_TR: begin
        cm_raddr = cell_addr(tr_r, tc_r);
        state_nxt = S_TR_CHK;
      end
      S_TR_CHK: begin
        // Walk parents back; the last cell before the start is the first step.
        if (q_par >= PAR_START) begin
          res_status_nxt = ST_STEP;
          res_dir_nxt = step_dir_r;
          res_row_nxt = step_row_r[FIELD_W-1:0];
          res_col_nxt = step_col_r[FIELD_W-1:0];
          res_goal_nxt = (step_row_r == dr_r) && (step_col_r == dc_r);
          state_nxt = S_DONE;
        end else begin
          step_dir_nxt = q_par[1:0];
          step_row_nxt = tr_r;
          step_col_nxt = tc_r;
          case (q_par[1:0])
            DIR_LEFT: tc_nxt = tc_r + COORD_W'(1);
            DIR_RIGHT: tc_nxt = tc_r - COORD_W'(1);
            DIR_UP: tr_nxt = tr_r + COORD_W'(1);
            DIR_DOWN: tr_nxt = tr_r - COORD_W'(1);
            default: ;
          endcase
          state_nxt = S_TR;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_dir_nxt = res_dir_r;
          out_row_nxt = res_row_r;
          out_col_nxt = res_col_r;
          out_goal_nxt = res_goal_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      sweep_r <= '0;
      rows_r <= AREA_RESET;
      cols_r <= AREA_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      out_valid_r <= out_valid_nxt;
      sr_r <= sr_nxt;
      sc_r <= sc_nxt;
      dr_r <= dr_nxt;
      dc_r <= dc_nxt;
      cr_r <= cr_nxt;
      cc_r <= cc_nxt;
      nr_r <= nr_nxt;
      nc_r <= nc_nxt;
      tr_r <= tr_nxt;
      tc_r <= tc_nxt;
      step_row_r <= step_row_nxt;
      step_col_r <= step_col_nxt;
      step_dir_r <= step_dir_nxt;
      d_r <= d_nxt;
      g_r <= g_nxt;
      fn_r <= fn_nxt;
      res_status_r <= res_status_nxt;
      res_dir_r <= res_dir_nxt;
      res_row_r <= res_row_nxt;
      res_col_r <= res_col_nxt;
      res_goal_r <= res_goal_nxt;
      out_status_r <= out_status_nxt;
      out_dir_r <= out_dir_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      out_goal_r <= out_goal_nxt;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.step_dir = out_dir_r;
  assign out_ch.step_row = out_row_r;
  assign out_ch.step_col = out_col_r;
  assign out_ch.step_reaches_goal = out_goal_r;

  `GAS_ASSERT_IMPL(a_zero_payload, clk, rst_n, out_valid_r && out_status_r != ST_STEP,
                   out_dir_r == '0 && out_row_r == '0 && out_col_r == '0 && !out_goal_r)
  `GAS_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, hp_req.pop, !hp_rsp.empty)
  `GAS_ASSERT_IMPL(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_DONE)

endmodule
